// File: hw/rtl/quadrupole_field_with_decapole_defines.svh
// Assertion macros for the quadrupole field block.
`ifndef QUADRUPOLE_FIELD_WITH_DECAPOLE_DEFINES_SVH
`define QUADRUPOLE_FIELD_WITH_DECAPOLE_DEFINES_SVH
`ifndef ASSERT_OFF
`define QFD_ASSERT_IMPL(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define QFD_ASSERT_NEVER(label, clk, rst_n, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`else
`define QFD_ASSERT_IMPL(label, clk, rst_n, prop, msg)
`define QFD_ASSERT_NEVER(label, clk, rst_n, expr, msg)
`endif
`endif

// File: hw/rtl/qfd_pkg.sv
// Shared constants, types and arithmetic helpers for the quadrupole field block.
`timescale 1ns / 1ps
`default_nettype none
package qfd_pkg;
	localparam int POS_BITS_DEF   = 24;
	localparam int COEF_BITS_DEF  = 16;
	localparam int FIELD_BITS_DEF = 32;
	localparam int CFG_DATA_BITS  = 48;
	localparam int CFG_IDX_BITS   = 3;

	typedef enum logic [CFG_IDX_BITS-1:0] {
		REG_GRADIENT = 3'd0,
		REG_MSCALE   = 3'd1,
		REG_RADSQ    = 3'd2,
		REG_ORIGIN   = 3'd3,
		REG_ROW0     = 3'd4,
		REG_ROW1     = 3'd5,
		REG_ROW2     = 3'd6
	} reg_idx_t;

	// Clamp a wide signed value to the signed 32-bit range.
	function automatic logic signed [31:0] sat32(input logic signed [79:0] v);
		logic signed [79:0] hi;
		logic signed [79:0] lo;
		hi = 80'sh7fffffff;
		lo = -hi - 80'sd1;
		if (v > hi)
			sat32 = 32'sh7fffffff;
		else if (v < lo)
			sat32 = 32'sh80000000;
		else
			sat32 = v[31:0];
	endfunction
endpackage
`default_nettype wire

// File: hw/rtl/qfd_frame.sv
// Front end: origin offset, aperture test and rotation into the magnet frame.
`timescale 1ns / 1ps
`default_nettype none
module qfd_frame #(
	parameter int POS_BITS  = qfd_pkg::POS_BITS_DEF,
	parameter int COEF_BITS = qfd_pkg::COEF_BITS_DEF
) (
	input  wire                         clk,
	input  wire                         arst_n,
	input  wire                         in_vld,
	input  wire signed [POS_BITS-1:0]   px,
	input  wire signed [POS_BITS-1:0]   py,
	input  wire signed [POS_BITS-1:0]   pz,
	input  wire [47:0]                  radius_sq,
	input  wire [47:0]                  origin,
	input  wire [3*COEF_BITS-1:0]       mcol0,
	input  wire [3*COEF_BITS-1:0]       mcol1,
	output logic                        out_vld,
	output logic                        out_inside,
	output logic signed [POS_BITS-1:0]  lx,
	output logic signed [POS_BITS-1:0]  ly
);
	import qfd_pkg::*;
	localparam int GW = POS_BITS + 10;
	localparam int PW = GW + COEF_BITS;
	localparam int FR = COEF_BITS - 2;

	// Stage 1: subtract the origin.
	logic                 vld_s1;
	logic signed [GW-1:0] g_s1 [3];
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_s1 <= 1'b0;
		else
			vld_s1 <= in_vld;
	end
	always_ff @(posedge clk) begin
		g_s1[0] <= GW'(px) - (GW'($signed(origin[15:0])) <<< 8);
		g_s1[1] <= GW'(py) - (GW'($signed(origin[31:16])) <<< 8);
		g_s1[2] <= GW'(pz) - (GW'($signed(origin[47:32])) <<< 8);
	end

	// Stage 2: squares and matrix products.
	logic                 vld_s2;
	logic                 near_s2;
	logic [49:0]          sq_s2 [2];
	logic signed [PW-1:0] p_s2 [2][3];
	logic                 near_c;
	logic signed [49:0]   gsx_c;
	logic signed [49:0]   gsy_c;
	always_comb begin
		near_c = (g_s1[0] > -(GW'(1) <<< 24)) && (g_s1[0] < (GW'(1) <<< 24)) &&
			(g_s1[1] > -(GW'(1) <<< 24)) && (g_s1[1] < (GW'(1) <<< 24));
		// The offsets fit in 25 signed bits whenever the point is near.
		gsx_c  = 50'($signed(g_s1[0][24:0]));
		gsy_c  = 50'($signed(g_s1[1][24:0]));
	end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_s2 <= 1'b0;
		else
			vld_s2 <= vld_s1;
	end
	always_ff @(posedge clk) begin
		near_s2  <= near_c;
		sq_s2[0] <= $unsigned(gsx_c * gsx_c);
		sq_s2[1] <= $unsigned(gsy_c * gsy_c);
		for (int i = 0; i < 3; i++) begin
			p_s2[0][i] <= PW'(g_s1[i]) * PW'($signed(mcol0[i*COEF_BITS +: COEF_BITS]));
			p_s2[1][i] <= PW'(g_s1[i]) * PW'($signed(mcol1[i*COEF_BITS +: COEF_BITS]));
		end
	end

	// Stage 3: aperture compare and saturated local coordinates.
	logic signed [PW+1:0] s0;
	logic signed [PW+1:0] s1;
	logic signed [PW+1:0] h0;
	logic signed [PW+1:0] h1;
	logic signed [PW+1:0] pmax;
	logic [50:0]          rq;
	always_comb begin
		s0   = (PW+2)'(p_s2[0][0]) + (PW+2)'(p_s2[0][1]) + (PW+2)'(p_s2[0][2]);
		s1   = (PW+2)'(p_s2[1][0]) + (PW+2)'(p_s2[1][1]) + (PW+2)'(p_s2[1][2]);
		h0   = s0 >>> FR;
		h1   = s1 >>> FR;
		pmax = (PW+2)'((64'sd1 <<< (POS_BITS-1)) - 64'sd1);
		rq   = 51'(sq_s2[0]) + 51'(sq_s2[1]);
	end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_vld <= 1'b0;
		else
			out_vld <= vld_s2;
	end
	always_ff @(posedge clk) begin
		out_inside <= near_s2 && (rq < 51'(radius_sq));
		lx <= (h0 > pmax) ? POS_BITS'(pmax) : (h0 < -pmax - 1) ? POS_BITS'(-pmax - 1)
			: POS_BITS'(h0);
		ly <= (h1 > pmax) ? POS_BITS'(pmax) : (h1 < -pmax - 1) ? POS_BITS'(-pmax - 1)
			: POS_BITS'(h1);
	end
endmodule
`default_nettype wire

// File: hw/rtl/qfd_poly.sv
// Multipole polynomial: z^2, z^4, scaled term and local field, with each product registered.
`timescale 1ns / 1ps
`default_nettype none
module qfd_poly #(
	parameter int POS_BITS   = qfd_pkg::POS_BITS_DEF,
	parameter int FIELD_BITS = qfd_pkg::FIELD_BITS_DEF
) (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire                          in_vld,
	input  wire                          in_inside,
	input  wire signed [POS_BITS-1:0]    lx,
	input  wire signed [POS_BITS-1:0]    ly,
	input  wire signed [31:0]            gradient,
	input  wire signed [31:0]            mscale,
	output logic                         out_vld,
	output logic                         out_inside,
	output logic signed [FIELD_BITS-1:0] bl0,
	output logic signed [FIELD_BITS-1:0] bl1
);
	import qfd_pkg::*;
	localparam int D = 6;
	logic                      v_q   [D];
	logic                      in_q  [D];
	logic signed [POS_BITS-1:0] x_q  [D];
	logic signed [POS_BITS-1:0] y_q  [D];

	// Valid and coordinate shift line along the stages.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < D; i++)
				v_q[i] <= 1'b0;
		end else begin
			v_q[0] <= in_vld;
			for (int i = 1; i < D; i++)
				v_q[i] <= v_q[i-1];
		end
	end
	always_ff @(posedge clk) begin
		in_q[0] <= in_inside;
		x_q[0]  <= lx;
		y_q[0]  <= ly;
		for (int i = 1; i < D; i++) begin
			in_q[i] <= in_q[i-1];
			x_q[i]  <= x_q[i-1];
			y_q[i]  <= y_q[i-1];
		end
	end

	// Products, each registered before the next use.
	logic signed [79:0] xx_s1, yy_s1, xy_s1;
	logic signed [31:0] a_s2, b_s2;
	logic signed [79:0] aa_s3, bb_s3, ab_s3;
	logic signed [31:0] c_s4, d_s4;
	logic signed [79:0] mc_s5, md_s5;
	logic signed [31:0] hr_s6, hi_s6;
	logic signed [79:0] p0_s7, p1_s7, p2_s7, p3_s7;
	logic signed [31:0] ux_s8, uy_s8;
	logic signed [79:0] gx_s9, gy_s9;
	logic               v7, v8, v9, i7, i8, i9;
	logic signed [79:0] mr, mi, fmax, tx, ty;
	logic signed [POS_BITS-1:0] x7, y7, lx_d, ly_d;
	always_ff @(posedge clk) begin
		xx_s1 <= 80'(lx) * 80'(lx);
		yy_s1 <= 80'(ly) * 80'(ly);
		xy_s1 <= 80'(lx) * 80'(ly);
		a_s2  <= sat32((xx_s1 - yy_s1) >>> 16);
		b_s2  <= sat32(xy_s1 >>> 15);
		aa_s3 <= 80'(a_s2) * 80'(a_s2);
		bb_s3 <= 80'(b_s2) * 80'(b_s2);
		ab_s3 <= 80'(a_s2) * 80'(b_s2);
		c_s4  <= sat32((aa_s3 - bb_s3) >>> 16);
		d_s4  <= sat32(ab_s3 >>> 15);
		mc_s5 <= 80'(mscale) * 80'(c_s4);
		md_s5 <= 80'(mscale) * 80'(d_s4);
		hr_s6 <= sat32(mc_s5 >>> 16);
		hi_s6 <= sat32(md_s5 >>> 16);
		p0_s7 <= 80'(hr_s6) * 80'(x_q[5]);
		p1_s7 <= 80'(hi_s6) * 80'(y_q[5]);
		p2_s7 <= 80'(hr_s6) * 80'(y_q[5]);
		p3_s7 <= 80'(hi_s6) * 80'(x_q[5]);
		i7    <= in_q[5];
		i8    <= i7;
		i9    <= i8;
		ux_s8 <= sat32(80'(ly_d) + mi);
		uy_s8 <= sat32(80'(lx_d) + mr);
		gx_s9 <= 80'(gradient) * 80'(ux_s8);
		gy_s9 <= 80'(gradient) * 80'(uy_s8);
		bl0   <= FIELD_BITS'(tx);
		bl1   <= FIELD_BITS'(ty);
		out_inside <= i9;
		x7 <= x_q[5];
		y7 <= y_q[5];
	end
	assign lx_d = x7;
	assign ly_d = y7;
	always_comb begin
		mr   = (p0_s7 >>> 16) - (p1_s7 >>> 16);
		mi   = (p2_s7 >>> 16) + (p3_s7 >>> 16);
		fmax = (80'sd1 <<< (FIELD_BITS-1)) - 80'sd1;
		tx   = gx_s9 >>> 16;
		ty   = gy_s9 >>> 16;
		if (tx > fmax) tx = fmax;
		else if (tx < -fmax - 1) tx = -fmax - 1;
		if (ty > fmax) ty = fmax;
		else if (ty < -fmax - 1) ty = -fmax - 1;
	end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v7 <= 1'b0;
			v8 <= 1'b0;
			v9 <= 1'b0;
			out_vld <= 1'b0;
		end else begin
			v7 <= v_q[5];
			v8 <= v7;
			v9 <= v8;
			out_vld <= v9;
		end
	end
endmodule
`default_nettype wire

// File: hw/rtl/qfd_back.sv
// Back end: rotation of the local field into the global frame with saturation.
`timescale 1ns / 1ps
`default_nettype none
module qfd_back #(
	parameter int COEF_BITS  = qfd_pkg::COEF_BITS_DEF,
	parameter int FIELD_BITS = qfd_pkg::FIELD_BITS_DEF
) (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire                          in_vld,
	input  wire                          in_inside,
	input  wire signed [FIELD_BITS-1:0]  bl0,
	input  wire signed [FIELD_BITS-1:0]  bl1,
	input  wire [47:0]                   row0,
	input  wire [47:0]                   row1,
	input  wire [47:0]                   row2,
	output logic                         out_vld,
	output logic                         out_inside,
	output logic signed [FIELD_BITS-1:0] fx,
	output logic signed [FIELD_BITS-1:0] fy,
	output logic signed [FIELD_BITS-1:0] fz
);
	import qfd_pkg::*;
	localparam int FR = COEF_BITS - 2;
	localparam int W  = FIELD_BITS + COEF_BITS + 2;
	logic [47:0]          rows [3];
	logic signed [W-1:0]  p_s1 [3][2];
	logic                 v_s1, i_s1;
	logic signed [W-1:0]  t [3];
	logic signed [W-1:0]  fmax;
	logic signed [W-1:0]  r [3];
	assign rows[0] = row0;
	assign rows[1] = row1;
	assign rows[2] = row2;

	// Stage 1: six coefficient products.
	always_ff @(posedge clk) begin
		i_s1 <= in_inside;
		for (int i = 0; i < 3; i++) begin
			p_s1[i][0] <= W'(bl0) * W'($signed(rows[i][0 +: COEF_BITS]));
			p_s1[i][1] <= W'(bl1) * W'($signed(rows[i][COEF_BITS +: COEF_BITS]));
		end
	end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1    <= 1'b0;
			out_vld <= 1'b0;
		end else begin
			v_s1    <= in_vld;
			out_vld <= v_s1;
		end
	end

	// Stage 2: floor shifts, sum, clamp, sign flip of x and y, and aperture gating.
	always_comb begin
		fmax = (W'(1) <<< (FIELD_BITS-1)) - W'(1);
		for (int i = 0; i < 3; i++) begin
			t[i] = (p_s1[i][0] >>> FR) + (p_s1[i][1] >>> FR);
			if (t[i] > fmax) t[i] = fmax;
			else if (t[i] < -fmax - 1) t[i] = -fmax - 1;
			r[i] = t[i];
		end
		for (int i = 0; i < 2; i++) begin
			r[i] = -t[i];
			if (r[i] > fmax) r[i] = fmax;
		end
	end
	always_ff @(posedge clk) begin
		out_inside <= i_s1;
		fx <= i_s1 ? FIELD_BITS'(r[0]) : '0;
		fy <= i_s1 ? FIELD_BITS'(r[1]) : '0;
		fz <= i_s1 ? FIELD_BITS'(r[2]) : '0;
	end
endmodule
`default_nettype wire

// File: hw/rtl/quadrupole_field_with_decapole.sv
// Start runs through the frame, polynomial and back-end blocks to done; one point accepted per cycle.
// The pipeline has no stall: busy is always low and the result strobe cannot be held off.
// Throughput is set by the multiplier stages, each registered, so one item per clock.
// Asynchronous active-low reset clears all valid bits and the configuration registers.
// Configuration registers reset to zero, which makes every point outside the aperture.
`timescale 1ns / 1ps
`default_nettype none
`include "quadrupole_field_with_decapole_defines.svh"
module quadrupole_field_with_decapole #(
	parameter int POS_BITS   = qfd_pkg::POS_BITS_DEF,
	parameter int COEF_BITS  = qfd_pkg::COEF_BITS_DEF,
	parameter int FIELD_BITS = qfd_pkg::FIELD_BITS_DEF
) (
	input  wire                                    clk,
	input  wire                                    arst_n,
	input  wire                                    start,
	output logic                                   busy,
	input  wire signed [POS_BITS-1:0]              pos_x,
	input  wire signed [POS_BITS-1:0]              pos_y,
	input  wire signed [POS_BITS-1:0]              pos_z,
	input  wire                                    cfg_we,
	input  wire [qfd_pkg::CFG_IDX_BITS-1:0]        cfg_idx,
	input  wire [qfd_pkg::CFG_DATA_BITS-1:0]       cfg_data,
	output logic                                   done,
	output logic signed [FIELD_BITS-1:0]           field_x,
	output logic signed [FIELD_BITS-1:0]           field_y,
	output logic signed [FIELD_BITS-1:0]           field_z,
	output logic                                   inside_aperture
);
	import qfd_pkg::*;
	logic signed [31:0] gradient_q, mscale_q;
	logic [47:0]        radsq_q, origin_q, row0_q, row1_q, row2_q;
	logic [3*COEF_BITS-1:0] mcol0, mcol1;
	logic               f_vld, f_in, p_vld, p_in, b_in;
	logic signed [POS_BITS-1:0]   lx, ly;
	logic signed [FIELD_BITS-1:0] bl0, bl1;
	logic               leak_c;

	assign busy = 1'b0;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gradient_q <= '0;
			mscale_q   <= '0;
			radsq_q    <= '0;
			origin_q   <= '0;
			row0_q     <= '0;
			row1_q     <= '0;
			row2_q     <= '0;
		end else if (cfg_we) begin
			case (reg_idx_t'(cfg_idx))
				REG_GRADIENT: gradient_q <= cfg_data[31:0];
				REG_MSCALE:   mscale_q   <= cfg_data[31:0];
				REG_RADSQ:    radsq_q    <= cfg_data;
				REG_ORIGIN:   origin_q   <= cfg_data;
				REG_ROW0:     row0_q     <= cfg_data;
				REG_ROW1:     row1_q     <= cfg_data;
				REG_ROW2:     row2_q     <= cfg_data;
				default: ;
			endcase
		end
	end

	// Matrix columns for the transpose rotation.
	always_comb begin
		mcol0 = {row2_q[0 +: COEF_BITS], row1_q[0 +: COEF_BITS], row0_q[0 +: COEF_BITS]};
		mcol1 = {row2_q[COEF_BITS +: COEF_BITS], row1_q[COEF_BITS +: COEF_BITS],
			row0_q[COEF_BITS +: COEF_BITS]};
	end

	qfd_frame #(.POS_BITS(POS_BITS), .COEF_BITS(COEF_BITS)) u_frame (
		.clk(clk), .arst_n(arst_n), .in_vld(start && !busy),
		.px(pos_x), .py(pos_y), .pz(pos_z), .radius_sq(radsq_q), .origin(origin_q),
		.mcol0(mcol0), .mcol1(mcol1), .out_vld(f_vld), .out_inside(f_in),
		.lx(lx), .ly(ly)
	);

	qfd_poly #(.POS_BITS(POS_BITS), .FIELD_BITS(FIELD_BITS)) u_poly (
		.clk(clk), .arst_n(arst_n), .in_vld(f_vld), .in_inside(f_in), .lx(lx), .ly(ly),
		.gradient(gradient_q), .mscale(mscale_q), .out_vld(p_vld), .out_inside(p_in),
		.bl0(bl0), .bl1(bl1)
	);

	qfd_back #(.COEF_BITS(COEF_BITS), .FIELD_BITS(FIELD_BITS)) u_back (
		.clk(clk), .arst_n(arst_n), .in_vld(p_vld), .in_inside(p_in),
		.bl0(bl0), .bl1(bl1), .row0(row0_q), .row1(row1_q), .row2(row2_q),
		.out_vld(done), .out_inside(b_in), .fx(field_x), .fy(field_y), .fz(field_z)
	);
	assign inside_aperture = b_in;

	// A nonzero field on a result beat outside the aperture.
	assign leak_c = done && !inside_aperture &&
		(field_x != '0 || field_y != '0 || field_z != '0);

	// Checks on busy, the aperture gating and the frame valid.
	`QFD_ASSERT_NEVER(a_busy_low, clk, arst_n, busy, "busy must stay low")
	`QFD_ASSERT_NEVER(a_zero_out, clk, arst_n, leak_c, "field outside aperture")
	`QFD_ASSERT_IMPL(a_lat, clk, arst_n, f_vld |-> $past(start, 3), "frame valid without start")
endmodule
`default_nettype wire
